FILE: hdl/plpr_pkg.sv
// Package for the periodic Laplacian residual block.
// Holds state encoding, transaction kind codes, register indexes and fixed constants.
// No dependencies.
package plpr_pkg;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_MUL1,
    S_COEF,
    S_MUL2,
    S_SRC,
    S_RES,
    S_CHK,
    S_DIV,
    S_FIN
  } state_t;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_EVAL = 1'b1;

  localparam logic CFG_GRID_SIZE    = 1'b0;
  localparam logic CFG_SCALE_FACTOR = 1'b1;

  localparam logic [6:0]  GRID_SIZE_RST    = 7'd64;
  localparam logic [17:0] SCALE_FACTOR_RST = 18'd65536;

  // 4*pi in unsigned Q4.28, split at bit 14
  localparam logic [17:0] FOURPI_HI = 18'd205887;
  localparam logic [13:0] FOURPI_LO = 14'd6818;

endpackage

FILE: hdl/periodic_laplacian_poisson_residual_top.sv
// Periodic seven-point Laplacian residual for one z-slice, Q16.16 values.
// Load writes one cell. Evaluate makes five reads through the single read port of the centre
// memory, steps through MUL1, COEF, MUL2, SRC, RES and CHK, then the bit-serial divider when
// the relative residual needs a quotient. One transaction in flight. Synchronous active-low
// reset clears state, config and out_valid; stores hold garbage until loaded.
// Depends on plpr_pkg.
module periodic_laplacian_poisson_residual_top #(
  parameter int MAX_GRID = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_stall,
  input  logic         in_kind,
  input  logic [5:0]   in_cell_x,
  input  logic [5:0]   in_cell_y,
  input  logic [31:0]  in_phi_below,
  input  logic [31:0]  in_phi_center,
  input  logic [31:0]  in_phi_above,
  input  logic [31:0]  in_density_contrast,
  output logic         out_valid,
  input  logic         out_stall,
  output logic [5:0]   out_x,
  output logic [5:0]   out_y,
  output logic [31:0]  out_density_out,
  output logic [31:0]  out_potential_out,
  output logic [63:0]  out_laplacian,
  output logic [63:0]  out_source_term,
  output logic [63:0]  out_residual,
  output logic [31:0]  out_relative_residual,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_index,
  input  logic [17:0]  cfg_data
);
  import plpr_pkg::*;

  localparam int NW    = $clog2(MAX_GRID + 1);
  localparam int GW    = (NW > 7) ? NW : 7;
  localparam int DEPTH = MAX_GRID * MAX_GRID;
  localparam int AW    = $clog2(DEPTH);

  state_t state_r, state_nxt;

  logic [6:0]  grid_size_r;
  logic [17:0] scale_factor_r;

  logic [GW-1:0] n_g;
  logic [NW-1:0] n_w;
  logic [2*NW-1:0] nn;
  always_comb begin
    if (grid_size_r < 7'd3) begin
      n_g = GW'(3);
    end else if (GW'(grid_size_r) > GW'(MAX_GRID)) begin
      n_g = GW'(MAX_GRID);
    end else begin
      n_g = GW'(grid_size_r);
    end
    n_w = NW'(n_g);
    nn  = (2*NW)'(n_w) * (2*NW)'(n_w);
  end

  logic in_range, in_acc, ld_we;
  assign in_range = (GW'(in_cell_x) < n_g) && (GW'(in_cell_y) < n_g);
  assign in_acc   = in_valid && !in_stall;
  assign ld_we    = in_acc && in_range && (in_kind == KIND_LOAD);
  assign in_stall = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  function automatic logic [AW-1:0] cell_addr(input logic [NW-1:0] xa, input logic [NW-1:0] ya);
    cell_addr = AW'(32'(xa) * MAX_GRID + 32'(ya));
  endfunction

  logic [NW-1:0] x_r, y_r;
  logic [5:0]    xo_r, yo_r;
  logic [2:0]    cnt_r;
  logic [NW-1:0] xp, xm, yp, ym;
  always_comb begin
    xp = (x_r + NW'(1) == n_w) ? '0 : x_r + NW'(1);
    xm = (x_r == '0) ? n_w - NW'(1) : x_r - NW'(1);
    yp = (y_r + NW'(1) == n_w) ? '0 : y_r + NW'(1);
    ym = (y_r == '0) ? n_w - NW'(1) : y_r - NW'(1);
  end

  logic [AW-1:0] wr_addr, rd_addr;
  assign wr_addr = cell_addr(NW'(in_cell_x), NW'(in_cell_y));
  always_comb begin
    case (cnt_r)
      3'd1:    rd_addr = cell_addr(xp, y_r);
      3'd2:    rd_addr = cell_addr(xm, y_r);
      3'd3:    rd_addr = cell_addr(x_r, yp);
      3'd4:    rd_addr = cell_addr(x_r, ym);
      default: rd_addr = cell_addr(x_r, y_r);
    endcase
  end

  logic [31:0] ctr_mem [DEPTH];
  logic [95:0] side_mem [DEPTH];
  logic [31:0] ctr_q;
  logic [95:0] side_q;
  always_ff @(posedge clk) begin
    if (ld_we) begin
      ctr_mem[wr_addr]  <= in_phi_center;
      side_mem[wr_addr] <= {in_density_contrast, in_phi_above, in_phi_below};
    end
    ctr_q  <= ctr_mem[rd_addr];
    side_q <= side_mem[rd_addr];
  end

  logic signed [35:0] acc_r;
  logic [31:0] c_r, dens_r, d_r;
  logic [35:0] a2_r;
  logic signed [53:0] lap_r;
  logic [53:0] p1_r;
  logic [49:0] p2_r;
  logic [39:0] coef_r;
  logic [51:0] hi_r;
  logic [52:0] lo_r;
  logic signed [63:0] src_r, res_r;
  logic [39:0] s_r;
  logic [63:0] r_r;
  logic [40:0] rem_r;
  logic [31:0] sh_r, q_r, rel_r;
  logic [4:0]  div_cnt_r;
  logic        out_valid_r;

  logic signed [35:0] c_s, ab_s;
  logic [39:0] m_mag;
  logic signed [64:0] diff;
  logic signed [63:0] res_sat;
  logic [41:0] div_t;
  logic        div_ge;
  always_comb begin
    c_s   = 36'(signed'(ctr_q));
    ab_s  = 36'(signed'(side_q[31:0])) + 36'(signed'(side_q[63:32]));
    m_mag = 40'((52'(hi_r) + 52'(lo_r >> 20)) >> 12);
    diff  = 65'(64'(lap_r)) - 65'(src_r);
    if (diff > 65'sh0_7FFF_FFFF_FFFF_FFFF) begin
      res_sat = 64'h7FFF_FFFF_FFFF_FFFF;
    end else if (diff < -65'sh8000_0000_0000_0000) begin
      res_sat = 64'h8000_0000_0000_0000;
    end else begin
      res_sat = 64'(diff);
    end
    div_t  = {rem_r, sh_r[31]};
    div_ge = (div_t >= 42'(s_r));
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc && in_range && (in_kind == KIND_EVAL)) state_nxt = S_READ;
      end
      S_READ: if (cnt_r == 3'd5) state_nxt = S_MUL1;
      S_MUL1: state_nxt = S_COEF;
      S_COEF: state_nxt = S_MUL2;
      S_MUL2: state_nxt = S_SRC;
      S_SRC:  state_nxt = S_RES;
      S_RES:  state_nxt = S_CHK;
      S_CHK: begin
        if (s_r == '0 || r_r >= (64'(s_r) << 16)) state_nxt = S_FIN;
        else state_nxt = S_DIV;
      end
      S_DIV:  if (div_cnt_r == 5'd31) state_nxt = S_FIN;
      S_FIN:  if (!out_valid_r || !out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      grid_size_r    <= GRID_SIZE_RST;
      scale_factor_r <= SCALE_FACTOR_RST;
      out_valid_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_GRID_SIZE:    grid_size_r    <= cfg_data[6:0];
          CFG_SCALE_FACTOR: scale_factor_r <= cfg_data;
          default: ;
        endcase
      end
      if (state_r == S_FIN && (!out_valid_r || !out_stall)) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        x_r   <= NW'(in_cell_x);
        y_r   <= NW'(in_cell_y);
        xo_r  <= in_cell_x;
        yo_r  <= in_cell_y;
        cnt_r <= '0;
      end
      S_READ: begin
        cnt_r <= cnt_r + 3'd1;
        a2_r  <= 36'(scale_factor_r) * 36'(scale_factor_r);
        if (cnt_r == 3'd1) begin
          acc_r  <= ab_s - ((c_s <<< 2) + (c_s <<< 1));
          c_r    <= ctr_q;
          dens_r <= side_q[95:64];
        end else if (cnt_r != 3'd0) begin
          acc_r <= acc_r + c_s;
        end
      end
      S_MUL1: begin
        lap_r <= 54'(acc_r) * 54'(signed'({1'b0, nn}));
        p1_r  <= 54'(a2_r) * 54'(FOURPI_HI);
        p2_r  <= 50'(a2_r) * 50'(FOURPI_LO);
        d_r   <= dens_r[31] ? 32'(-dens_r) : dens_r;
      end
      S_COEF: coef_r <= 40'((p1_r + 54'(p2_r >> 14)) >> 14);
      S_MUL2: begin
        hi_r <= 52'(coef_r[39:20]) * 52'(d_r);
        lo_r <= 53'(coef_r[19:0]) * 53'(d_r) + 53'h8000_0000;
      end
      S_SRC: begin
        s_r   <= m_mag;
        src_r <= dens_r[31] ? -64'(m_mag) : 64'(m_mag);
      end
      S_RES: begin
        res_r <= res_sat;
        r_r   <= res_sat[63] ? 64'(-res_sat) : 64'(res_sat);
      end
      S_CHK: begin
        if (s_r == '0) begin
          rel_r <= (r_r > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : r_r[31:0];
        end else begin
          rel_r <= 32'hFFFF_FFFF;
        end
        rem_r     <= 41'(r_r >> 16);
        sh_r      <= {r_r[15:0], 16'h0};
        q_r       <= '0;
        div_cnt_r <= '0;
      end
      S_DIV: begin
        rem_r     <= div_ge ? 41'(div_t - 42'(s_r)) : 41'(div_t);
        sh_r      <= sh_r << 1;
        q_r       <= {q_r[30:0], div_ge};
        div_cnt_r <= div_cnt_r + 5'd1;
        if (div_cnt_r == 5'd31) rel_r <= {q_r[30:0], div_ge};
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_x                 <= xo_r;
          out_y                 <= yo_r;
          out_density_out       <= dens_r;
          out_potential_out     <= c_r;
          out_laplacian         <= 64'(lap_r);
          out_source_term       <= src_r;
          out_residual          <= res_r;
          out_relative_residual <= rel_r;
        end
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;

  a_load_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_kind == KIND_LOAD) |=> state_r == S_IDLE)
    else $error("load left idle state");

  a_div_from_chk: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && $past(state_r) != S_DIV) |-> $past(state_r) == S_CHK && div_cnt_r == 5'd0)
    else $error("divider entered out of sequence");

  a_zero_rel: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_source_term == 64'd0 && out_residual == 64'd0)
      |-> out_relative_residual == 32'd0)
    else $error("relative residual nonzero for zero residual");

endmodule

FILE: bench/periodic_laplacian_poisson_residual_top_tb.sv
// Bench for the periodic seven-point Laplacian residual block: loads and evaluates
// against an in-bench predictor over several grid and scale settings, idle and stall phases.
// Depends on plpr_pkg and periodic_laplacian_poisson_residual_top.
`timescale 1ns / 100ps

module periodic_laplacian_poisson_residual_top_tb;
  import plpr_pkg::*;

  localparam int MAXG = 64;
  localparam longint unsigned FOUR_PI_Q28 = 64'd3373259426;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct {
    logic        kind;
    logic [5:0]  x, y;
    logic [31:0] below, centre, above, dens;
  } cell_txn_t;

  typedef struct {
    logic [5:0]  x, y;
    logic [31:0] dens, pot;
    logic [63:0] lap, src, res;
    logic [31:0] rel;
  } residual_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0, in_kind = 1'b0;
  logic [5:0] in_cell_x = '0, in_cell_y = '0;
  logic [31:0] in_phi_below = '0, in_phi_center = '0, in_phi_above = '0;
  logic [31:0] in_density_contrast = '0;
  logic in_stall, out_valid, out_stall = 1'b0;
  logic [5:0] out_x, out_y;
  logic [31:0] out_density_out, out_potential_out, out_relative_residual;
  logic [63:0] out_laplacian, out_source_term, out_residual;
  logic cfg_valid = 1'b0, cfg_ready, cfg_index = CFG_GRID_SIZE;
  logic [17:0] cfg_data = '0;

  periodic_laplacian_poisson_residual_top dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  cell_txn_t pending_cells[$];
  residual_t expected_residuals[$];
  longint below_m[MAXG*MAXG], centre_m[MAXG*MAXG], above_m[MAXG*MAXG], dens_m[MAXG*MAXG];
  bit loaded[MAXG*MAXG];
  int grid_n = 64;
  longint unsigned scale_a = 65536;
  int errors = 0;
  int send_idle_pct = 0, stall_pct = 0;
  bit pressure_on = 0, pressure_done = 0;
  int hold_cnt = 0;
  logic in_taken = 0, cfg_taken = 0;
  int cycles = 0;

  function automatic int eff_n();
    return grid_n < 3 ? 3 : (grid_n > MAXG ? MAXG : grid_n);
  endfunction

  function automatic longint source_of(longint delta);
    longint unsigned a2, p1, p2, coef, d;
    logic [127:0] prod;
    longint m;
    a2 = scale_a * scale_a;
    p1 = a2 * (FOUR_PI_Q28 >> 14);
    p2 = a2 * (FOUR_PI_Q28 & 64'h3FFF);
    coef = (p1 + (p2 >> 14)) >> 14;
    d = delta < 0 ? -delta : delta;
    prod = {64'd0, coef} * {64'd0, d} + 128'h8000_0000;
    m = longint'(prod >> 32);
    return delta < 0 ? -m : m;
  endfunction

  function automatic logic [31:0] relative_of(longint res, longint src);
    logic [63:0] r, s;
    logic [127:0] q;
    r = res < 0 ? -res : res;
    s = src < 0 ? -src : src;
    if (s == 0) return r > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : r[31:0];
    if (r >= (s << 16)) return 32'hFFFF_FFFF;
    q = ({64'd0, r} << 16) / {64'd0, s};
    return q[31:0];
  endfunction

  // Updates the shadow stores and queues the residual an evaluate should yield.
  task automatic apply_cell(cell_txn_t t);
    int n, idx, xp, xm, yp, ym;
    longint c, sum, lap, src, res;
    logic signed [64:0] diff;
    residual_t e;
    n = eff_n();
    pending_cells.push_back(t);
    if (t.x >= n || t.y >= n) return;
    idx = t.x * MAXG + t.y;
    if (t.kind == KIND_LOAD) begin
      below_m[idx] = longint'($signed(t.below));
      centre_m[idx] = longint'($signed(t.centre));
      above_m[idx] = longint'($signed(t.above));
      dens_m[idx] = longint'($signed(t.dens));
      loaded[idx] = 1;
      return;
    end
    xp = (t.x + 1 == n) ? 0 : t.x + 1;
    xm = (t.x == 0) ? n - 1 : t.x - 1;
    yp = (t.y + 1 == n) ? 0 : t.y + 1;
    ym = (t.y == 0) ? n - 1 : t.y - 1;
    c = centre_m[idx];
    sum = centre_m[xp*MAXG + t.y] + centre_m[xm*MAXG + t.y] + centre_m[t.x*MAXG + yp]
        + centre_m[t.x*MAXG + ym] + above_m[idx] + below_m[idx] - 6 * c;
    lap = sum * longint'(n * n);
    src = source_of(dens_m[idx]);
    diff = 65'(signed'(lap)) - 65'(signed'(src));
    if (diff > 65'sh0_7FFF_FFFF_FFFF_FFFF) res = 64'h7FFF_FFFF_FFFF_FFFF;
    else if (diff < -65'sh0_8000_0000_0000_0000) res = 64'h8000_0000_0000_0000;
    else res = diff[63:0];
    e.x = t.x; e.y = t.y;
    e.dens = dens_m[idx][31:0]; e.pot = c[31:0];
    e.lap = lap; e.src = src; e.res = res;
    e.rel = relative_of(res, src);
    expected_residuals.push_back(e);
  endtask

  function automatic logic [31:0] rnd_value();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'($urandom_range(0, 2000)) - 32'd1000;
      3: return 32'($urandom_range(0, 2000)) << 12;
      default: return $urandom;
    endcase
  endfunction

  task automatic load_cell(int x, int y, logic [31:0] b, c, a, d);
    cell_txn_t t;
    t.kind = KIND_LOAD; t.x = 6'(x); t.y = 6'(y);
    t.below = b; t.centre = c; t.above = a; t.dens = d;
    apply_cell(t);
  endtask

  task automatic load_random(int x, int y);
    load_cell(x, y, rnd_value(), rnd_value(), rnd_value(), rnd_value());
  endtask

  // Loads whatever an evaluate of (x, y) would read, then issues it.
  task automatic evaluate_cell(int x, int y);
    int n, idx[5];
    cell_txn_t t;
    n = eff_n();
    if (x < n && y < n) begin
      idx[0] = x*MAXG + y;
      idx[1] = ((x + 1) % n)*MAXG + y;
      idx[2] = ((x + n - 1) % n)*MAXG + y;
      idx[3] = x*MAXG + (y + 1) % n;
      idx[4] = x*MAXG + (y + n - 1) % n;
      foreach (idx[i]) if (!loaded[idx[i]]) load_random(idx[i] / MAXG, idx[i] % MAXG);
    end
    t.kind = KIND_EVAL; t.x = 6'(x); t.y = 6'(y);
    t.below = $urandom; t.centre = $urandom; t.above = $urandom; t.dens = $urandom;
    apply_cell(t);
  endtask

  task automatic wait_drained();
    while (pending_cells.size() != 0 || in_valid || expected_residuals.size() != 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [17:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    while (!cfg_taken) @(negedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_GRID_SIZE) grid_n = int'(val[6:0]);
    else scale_a = 64'(val);
  endtask

  always @(posedge clk) begin
    in_taken <= in_valid && !in_stall;
    cfg_taken <= cfg_valid && cfg_ready;
  end

  // Driver
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (pending_cells.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        cell_txn_t t;
        t = pending_cells.pop_front();
        in_valid <= 1'b1;
        in_kind <= t.kind; in_cell_x <= t.x; in_cell_y <= t.y;
        in_phi_below <= t.below; in_phi_center <= t.centre;
        in_phi_above <= t.above; in_density_contrast <= t.dens;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall, with one long hold-off
  always @(negedge clk) begin
    if (pressure_on && !pressure_done) begin
      out_stall <= 1'b1;
      hold_cnt <= hold_cnt + 1;
      if (hold_cnt == 400) pressure_done <= 1;
    end else begin
      out_stall <= $urandom_range(0, 99) < stall_pct;
    end
  end

  // Monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_residuals.size() == 0) begin
        $display("%0t: unexpected result x=%0d y=%0d", $time, out_x, out_y);
        errors++;
      end else begin
        residual_t e;
        e = expected_residuals.pop_front();
        if (out_x !== e.x)
          begin $display("%0t: x exp %h got %h", $time, e.x, out_x); errors++; end
        if (out_y !== e.y)
          begin $display("%0t: y exp %h got %h", $time, e.y, out_y); errors++; end
        if (out_density_out !== e.dens)
          begin $display("%0t: density exp %h got %h", $time, e.dens, out_density_out); errors++; end
        if (out_potential_out !== e.pot)
          begin $display("%0t: potential exp %h got %h", $time, e.pot, out_potential_out); errors++; end
        if (out_laplacian !== e.lap)
          begin $display("%0t: laplacian exp %h got %h", $time, e.lap, out_laplacian); errors++; end
        if (out_source_term !== e.src)
          begin $display("%0t: source exp %h got %h", $time, e.src, out_source_term); errors++; end
        if (out_residual !== e.res)
          begin $display("%0t: residual exp %h got %h", $time, e.res, out_residual); errors++; end
        if (out_relative_residual !== e.rel)
          begin $display("%0t: relative exp %h got %h", $time, e.rel,
                         out_relative_residual); errors++; end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int grids[13];
    int scales[13];
    int n, k;
    grids = '{64, 3, 4, 5, 0, 7, 8, 1, 13, 2, 127, 16, 64};
    scales = '{65536, 0, 262143, 65536, 1, 131072, 40000, 262143, 65536, 0, 98304, 1234, 65535};
    repeat (12) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Directed: corners, extremes, zero source, saturated relative residual
    load_cell(0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
    load_cell(63, 63, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
    load_cell(63, 0, 32'h0, 32'h0, 32'h0, 32'h7FFF_FFFF);
    load_cell(0, 63, 32'hFFFF_FFFF, 32'h1, 32'h0001_0000, 32'h0000_0001);
    load_cell(0, 1, 32'h0, 32'h0, 32'h0, 32'h0);
    load_cell(1, 0, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF);
    load_cell(62, 63, 32'h0, 32'h0001_0000, 32'h0, 32'h0);
    load_cell(63, 62, 32'h0, 32'h0, 32'h0, 32'h0);
    evaluate_cell(0, 0);
    evaluate_cell(63, 63);
    evaluate_cell(63, 0);
    evaluate_cell(0, 63);
    evaluate_cell(1, 0);
    evaluate_cell(0, 1);
    wait_drained();

    for (int p = 0; p < 13; p++) begin
      write_reg(CFG_GRID_SIZE, 18'(grids[p]));
      write_reg(CFG_SCALE_FACTOR, 18'(scales[p]));
      case (p % 4)
        0: begin send_idle_pct = 0; stall_pct = 0; end
        1: begin send_idle_pct = 56; stall_pct = 0; end
        2: begin send_idle_pct = 0; stall_pct = 56; end
        default: begin send_idle_pct = 34; stall_pct = 34; end
      endcase
      pressure_on = (p == 3);
      n = eff_n();
      k = 0;
      while (k < 45) begin
        int r;
        r = $urandom_range(0, 99);
        if (r < 10 && n < MAXG) begin
          if ($urandom_range(0, 1)) evaluate_cell($urandom_range(n, 63), $urandom_range(0, 63));
          else load_random($urandom_range(0, 63), $urandom_range(n, 63));
        end else if (r < 40) begin
          load_random($urandom_range(0, n - 1), $urandom_range(0, n - 1));
        end else begin
          evaluate_cell($urandom_range(0, n - 1), $urandom_range(0, n - 1));
        end
        k++;
        while (pending_cells.size() > 8) @(posedge clk);
      end
      wait_drained();
    end

    if (errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
